// ===== rtl/bsa_pkg.sv =====
// Shared types and constants of the background scroll animator.
package bsa_pkg;

  localparam int WORD_W  = 32;
  localparam int SPEED_W = 26;
  localparam int DIST_W  = 9;
  localparam int CMD_W   = 2;
  localparam int LAYER_W = 2;
  localparam int CHAN_W  = 3;

  // backgrounds per axis; the layer and channel fields are sized for four
  localparam int LAYERS  = 4;

  localparam logic [CMD_W-1:0] CMD_RESET = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SNAP  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd3;

  // integer bits kept when an idle channel is started
  localparam logic [DIST_W-1:0] INT_KEEP = 9'h1FF;

  typedef struct packed {
    logic              active;
    logic [WORD_W-1:0] step;
    logic [WORD_W-1:0] goal;
    logic [WORD_W-1:0] position;
  } chan_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              hit;    // start addresses this channel with a nonzero speed
    logic [WORD_W-1:0] speed;
    logic [DIST_W-1:0] span;
  } chan_op_t;

endpackage

// ===== rtl/bg_scroll_animator.sv =====
// Top level: channel state, command sequencer and result register.
//
//   port group | dir | meaning
//   in_*       | in  | one command beat: command, layer, speeds, distances
//   out_*      | out | one report beat per channel: channel, offset, running, last
//
// A command is taken on one edge, then walks the 2*LAYERS channels (8 at the default)
// one per cycle while out_* does not stall, through the shared step unit, which updates
// that channel and loads the result register. The next command is taken in the cycle
// after the last channel is loaded; in_stall holds off new commands during the walk.
// rst_n is synchronous and clears every channel and the sequencer.
// A stall on out_* holds the walk on the current channel until the beat is taken.
module bg_scroll_animator #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bsa_pkg::CMD_W-1:0]           in_command,
  input  logic [bsa_pkg::LAYER_W-1:0]         in_layer,
  input  logic signed [bsa_pkg::SPEED_W-1:0]  in_x_speed,
  input  logic signed [bsa_pkg::SPEED_W-1:0]  in_y_speed,
  input  logic [bsa_pkg::DIST_W-1:0]          in_x_distance,
  input  logic [bsa_pkg::DIST_W-1:0]          in_y_distance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bsa_pkg::CHAN_W-1:0]          out_channel,
  output logic signed [bsa_pkg::WORD_W-1:0]   out_offset,
  output logic                                out_running,
  output logic                                out_last
);

  localparam int CH = 2 * bsa_pkg::LAYERS;
  localparam int CW = $clog2(CH);
  localparam logic [CW-1:0] LAST_CH = CW'(CH - 1);
  localparam logic [CW-1:0] Y_BASE  = CW'(bsa_pkg::LAYERS);

  logic                                busy_r;
  logic [CW-1:0]                       ch_r;
  logic [bsa_pkg::CMD_W-1:0]           cmd_r;
  logic [bsa_pkg::LAYER_W-1:0]         layer_r;
  logic signed [bsa_pkg::SPEED_W-1:0]  x_speed_r;
  logic signed [bsa_pkg::SPEED_W-1:0]  y_speed_r;
  logic [bsa_pkg::DIST_W-1:0]          x_dist_r;
  logic [bsa_pkg::DIST_W-1:0]          y_dist_r;

  logic [CH-1:0]               active_r;
  logic [bsa_pkg::WORD_W-1:0]  step_r [CH];
  logic [bsa_pkg::WORD_W-1:0]  goal_r [CH];
  logic [bsa_pkg::WORD_W-1:0]  pos_r  [CH];

  logic                        out_valid_r;
  logic [bsa_pkg::CHAN_W-1:0]  out_channel_r;
  logic [bsa_pkg::WORD_W-1:0]  out_offset_r;
  logic                        out_running_r;
  logic                        out_last_r;

  logic                        accept;
  logic                        advance;
  logic                        is_y;
  logic [CW-1:0]               ch_layer;
  logic [bsa_pkg::WORD_W-1:0]  sel_speed;
  bsa_pkg::chan_op_t           op;
  bsa_pkg::chan_t              cur;
  bsa_pkg::chan_t              upd;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign advance  = busy_r && (!out_valid_r || !out_stall);

  assign is_y      = (ch_r >= Y_BASE);
  assign ch_layer  = is_y ? (ch_r - Y_BASE) : ch_r;
  assign sel_speed = is_y ? bsa_pkg::WORD_W'(y_speed_r) : bsa_pkg::WORD_W'(x_speed_r);

  always_comb begin
    op.cmd   = cmd_r;
    op.speed = sel_speed;
    op.span  = is_y ? y_dist_r : x_dist_r;
    // a layer number at or above LAYERS never matches a channel
    op.hit   = (cmd_r == bsa_pkg::CMD_START) && (sel_speed != '0) &&
               (4'(ch_layer) == 4'(layer_r));
  end

  always_comb begin
    cur.active   = active_r[ch_r];
    cur.step     = step_r[ch_r];
    cur.goal     = goal_r[ch_r];
    cur.position = pos_r[ch_r];
  end

  bsa_step_unit #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_step (
    .op  (op),
    .cur (cur),
    .nxt (upd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ch_r   <= '0;
    end else if (accept) begin
      busy_r <= 1'b1;
      ch_r   <= '0;
    end else if (advance) begin
      if (ch_r == LAST_CH) begin
        busy_r <= 1'b0;
      end else begin
        ch_r <= ch_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= in_command;
      layer_r   <= in_layer;
      x_speed_r <= in_x_speed;
      y_speed_r <= in_y_speed;
      x_dist_r  <= in_x_distance;
      y_dist_r  <= in_y_distance;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      for (int i = 0; i < CH; i++) begin
        step_r[i] <= '0;
        goal_r[i] <= '0;
        pos_r[i]  <= '0;
      end
    end else if (advance) begin
      active_r[ch_r] <= upd.active;
      step_r[ch_r]   <= upd.step;
      goal_r[ch_r]   <= upd.goal;
      pos_r[ch_r]    <= upd.position;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel_r <= bsa_pkg::CHAN_W'(ch_r);
      out_offset_r  <= upd.position;
      out_running_r <= upd.active;
      out_last_r    <= (ch_r == LAST_CH);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_offset  = out_offset_r;
  assign out_running = out_running_r;
  assign out_last    = out_last_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && (ch_r == '0))
    else $error("walk did not start at channel zero");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (ch_r == LAST_CH) |=> !busy_r && out_valid_r && out_last_r)
    else $error("walk did not end after the last channel");

  a_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd_r == bsa_pkg::CMD_RESET) && (ch_r == LAST_CH) |=> active_r == '0)
    else $error("reset command left a channel running");

  a_snap_stops: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (cmd_r == bsa_pkg::CMD_SNAP) |=> !out_running_r)
    else $error("snap left a channel running");

endmodule

// ===== rtl/bsa_step_unit.sv =====
// Shared adder and compare that update one scroll channel per cycle while the walk is not stalled.
module bsa_step_unit #(
  parameter int FRACTION_BITS = 16
) (
  input  bsa_pkg::chan_op_t op,
  input  bsa_pkg::chan_t    cur,
  output bsa_pkg::chan_t    nxt
);

  localparam logic [bsa_pkg::WORD_W-1:0] INT_MASK =
    {{(bsa_pkg::WORD_W-bsa_pkg::DIST_W){1'b0}}, bsa_pkg::INT_KEEP} << FRACTION_BITS;

  logic [bsa_pkg::WORD_W-1:0] add_a;
  logic [bsa_pkg::WORD_W-1:0] add_b;
  logic                       add_sub;
  logic [bsa_pkg::WORD_W-1:0] sum;
  logic [bsa_pkg::WORD_W-1:0] start_base;
  logic [bsa_pkg::WORD_W-1:0] dist_fx;
  logic                       step_pos;
  logic                       stop;

  assign dist_fx    = {{(bsa_pkg::WORD_W-bsa_pkg::DIST_W){1'b0}}, op.span} << FRACTION_BITS;
  assign start_base = cur.active ? cur.goal : (cur.position & INT_MASK);

  // one adder: offset plus speed on a tick, base plus or minus distance on a start
  always_comb begin
    if (op.cmd == bsa_pkg::CMD_TICK) begin
      add_a   = cur.position;
      add_b   = cur.step;
      add_sub = 1'b0;
    end else begin
      add_a   = start_base;
      add_b   = dist_fx;
      add_sub = op.speed[bsa_pkg::WORD_W-1];
    end
  end

  assign sum = add_a + (add_sub ? ~add_b : add_b) + {{(bsa_pkg::WORD_W-1){1'b0}}, add_sub};

  assign step_pos = (cur.step != '0) && !cur.step[bsa_pkg::WORD_W-1];
  assign stop = (step_pos && ($signed(sum) >= $signed(cur.goal))) ||
                (cur.step[bsa_pkg::WORD_W-1] && ($signed(cur.goal) >= $signed(sum)));

  always_comb begin
    nxt = cur;
    case (op.cmd)
      bsa_pkg::CMD_RESET: begin
        nxt = '0;
      end
      bsa_pkg::CMD_START: begin
        if (op.hit) begin
          nxt.step     = op.speed;
          nxt.goal     = sum;
          nxt.active   = 1'b1;
          nxt.position = cur.active ? cur.position : start_base;
        end
      end
      bsa_pkg::CMD_SNAP: begin
        if (cur.active) begin
          nxt.position = cur.goal;
          nxt.active   = 1'b0;
        end
      end
      bsa_pkg::CMD_TICK: begin
        if (cur.active) begin
          nxt.position = stop ? cur.goal : sum;
          nxt.active   = !stop;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule
